@@ design/ptsm_pkg.sv @@
// Package for the prime test and square-root map block.
// Holds the control and status types, the microprogram and output limits.
// No dependencies.
`timescale 1ns / 1ps

package ptsm_pkg;

  // Result word width and saturation limits for the pass-through path
  localparam int OUT_W = 48;
  localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_LO = -64'sh0000_8000_0000_0000;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT_D,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_D_ADD2,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_EMIT_PRIME,
    OP_EMIT_PASS
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_TRIVIAL,
    C_TWO,
    C_SQ_GT,
    C_CNT_MORE,
    C_REM_ZERO,
    C_OUT_BUSY
  } cond_t;

  localparam int UC_DEPTH = 14;
  localparam int STEP_W   = $clog2(UC_DEPTH);
  typedef logic [STEP_W-1:0] step_t;

  // Jump targets
  localparam step_t ST_IDLE       = STEP_W'(0);
  localparam step_t ST_LOOP       = STEP_W'(3);
  localparam step_t ST_DIV        = STEP_W'(5);
  localparam step_t ST_ROOT       = STEP_W'(8);
  localparam step_t ST_ROOTL      = STEP_W'(9);
  localparam step_t ST_PRIME_WAIT = STEP_W'(10);
  localparam step_t ST_PASS_WAIT  = STEP_W'(12);

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  accept;
  } ucode_t;

  // Control to the datapath
  typedef struct packed {
    op_t  op;
    logic accept;
  } ctrl_t;

  // Status back to the sequencer
  typedef struct packed {
    logic no_in;
    logic trivial;
    logic is_two;
    logic sq_gt;
    logic cnt_more;
    logic rem_zero;
    logic out_busy;
  } status_t;

  // Microprogram: take a word, screen it, trial-divide, then root or pass
  localparam ucode_t UCODE [UC_DEPTH] = '{
    '{OP_LOAD,       C_NO_IN,    ST_IDLE,       1'b1},  // wait for a word
    '{OP_INIT_D,     C_TRIVIAL,  ST_PASS_WAIT,  1'b0},  // small or even
    '{OP_NOP,        C_TWO,      ST_ROOT,       1'b0},  // two is prime
    '{OP_MUL,        C_NEVER,    ST_IDLE,       1'b0},  // d squared
    '{OP_DIV_INIT,   C_SQ_GT,    ST_ROOT,       1'b0},  // no divisor left
    '{OP_DIV_STEP,   C_CNT_MORE, ST_DIV,        1'b0},  // remainder bits
    '{OP_D_ADD2,     C_REM_ZERO, ST_PASS_WAIT,  1'b0},  // divides: composite
    '{OP_NOP,        C_ALWAYS,   ST_LOOP,       1'b0},
    '{OP_ROOT_INIT,  C_NEVER,    ST_IDLE,       1'b0},
    '{OP_ROOT_STEP,  C_CNT_MORE, ST_ROOTL,      1'b0},  // root digits
    '{OP_NOP,        C_OUT_BUSY, ST_PRIME_WAIT, 1'b0},
    '{OP_EMIT_PRIME, C_ALWAYS,   ST_IDLE,       1'b0},
    '{OP_NOP,        C_OUT_BUSY, ST_PASS_WAIT,  1'b0},
    '{OP_EMIT_PASS,  C_ALWAYS,   ST_IDLE,       1'b0}
  };

endpackage

@@ design/ptsm_if.sv @@
// Handshake interfaces for the input and result channels.
// Depends on ptsm_pkg for the result width.
`timescale 1ns / 1ps

interface ptsm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_in;
  logic               last_in;

  modport source (output valid, output value_in, output last_in, input ready);
  modport sink   (input valid, input value_in, input last_in, output ready);
endinterface

interface ptsm_out_if
  import ptsm_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  mapped_value;
  logic                     prime_flag;
  logic                     last_out;

  modport source (output valid, output mapped_value, output prime_flag,
                  output last_out, input ready);
  modport sink   (input valid, input mapped_value, input prime_flag,
                  input last_out, output ready);
endinterface

@@ design/ptsm_seq.sv @@
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on ptsm_pkg.
`timescale 1ns / 1ps

module ptsm_seq
  import ptsm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  step_t  step;
  step_t  step_next;
  ucode_t uw;
  logic   take;

  assign uw = UCODE[step];

  // Condition select
  always_comb begin
    unique case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = status.no_in;
      C_TRIVIAL:  take = status.trivial;
      C_TWO:      take = status.is_two;
      C_SQ_GT:    take = status.sq_gt;
      C_CNT_MORE: take = status.cnt_more;
      C_REM_ZERO: take = status.rem_zero;
      C_OUT_BUSY: take = status.out_busy;
      default:    take = 1'b0;
    endcase
  end

  assign step_next = take ? uw.target : step_t'(step + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.op     = uw.op;
  assign ctrl.accept = uw.accept;

endmodule

@@ design/ptsm_datapath.sv @@
// Datapath: operand registers, squarer, bit-serial remainder unit,
// digit-serial square root and the result register. Depends on ptsm_pkg
// and the channel interfaces.
`timescale 1ns / 1ps

module ptsm_datapath
  import ptsm_pkg::*;
#(
  parameter int VW = 32,
  parameter int FB = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_t      ctrl,
  output status_t    status,
  ptsm_in_if.sink    in_ch,
  ptsm_out_if.source out_ch
);

  localparam int NW      = VW - 1;            // magnitude bits of a positive value
  localparam int PAIRS   = (VW + 1) / 2;
  localparam int DW      = PAIRS + 1;         // divisor width
  localparam int RW      = PAIRS + FB;        // root width
  localparam int CNT_MAX = (NW > RW) ? NW : RW;
  localparam int CW      = $clog2(CNT_MAX + 1);

  logic signed [VW-1:0]   vs;
  logic                   last_q;
  logic [NW-1:0]          n;
  logic [DW-1:0]          d;
  logic [2*DW-1:0]        sq;
  logic [DW:0]            dr;
  logic [NW-1:0]          dsh;
  logic [CW-1:0]          cnt;
  logic [RW-1:0]          root;
  logic [RW+1:0]          srem;
  logic [2*RW-1:0]        rsh;

  logic [DW:0]            div_try;
  logic                   div_ge;
  logic [RW+1:0]          rt_rem;
  logic [RW+1:0]          rt_trial;
  logic                   rt_ge;
  logic signed [63:0]     scaled;
  logic [OUT_W-1:0]       pass_val;

  logic                   o_valid;
  logic [OUT_W-1:0]       o_value;
  logic                   o_prime;
  logic                   o_last;

  assign n = vs[NW-1:0];

  // Remainder step: shift in one dividend bit, subtract if it fits
  assign div_try = {dr[DW-1:0], dsh[NW-1]};
  assign div_ge  = div_try >= {1'b0, d};

  // Root step: bring down one bit pair, try 4*root+1
  assign rt_rem   = {srem[RW-1:0], rsh[2*RW-1 -: 2]};
  assign rt_trial = {root, 2'b01};
  assign rt_ge    = rt_rem >= rt_trial;

  // Pass-through scaling with saturation
  always_comb begin
    scaled = 64'(vs) <<< FB;
    if (scaled > SAT_HI) begin
      pass_val = SAT_HI[OUT_W-1:0];
    end else if (scaled < SAT_LO) begin
      pass_val = SAT_LO[OUT_W-1:0];
    end else begin
      pass_val = scaled[OUT_W-1:0];
    end
  end

  // Status to the sequencer
  assign status.no_in    = !in_ch.valid;
  assign status.trivial  = (vs <= VW'(1)) || (!vs[0] && (vs != VW'(2)));
  assign status.is_two   = vs == VW'(2);
  assign status.sq_gt    = sq > {{(2*DW-NW){1'b0}}, n};
  assign status.cnt_more = cnt > CW'(1);
  assign status.rem_zero = dr == '0;
  assign status.out_busy = o_valid && !out_ch.ready;

  // No word is taken while in reset
  assign in_ch.ready = ctrl.accept && !rst;

  // Working registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (in_ch.valid) begin
          vs     <= in_ch.value_in[VW-1:0];
          last_q <= in_ch.last_in;
        end
      end
      OP_INIT_D: d <= DW'(3);
      OP_MUL:    sq <= d * d;
      OP_DIV_INIT: begin
        dr  <= '0;
        dsh <= n;
        cnt <= CW'(NW);
      end
      OP_DIV_STEP: begin
        dr  <= div_ge ? (div_try - {1'b0, d}) : div_try;
        dsh <= {dsh[NW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      OP_D_ADD2: d <= d + DW'(2);
      OP_ROOT_INIT: begin
        root <= '0;
        srem <= '0;
        rsh  <= {{(2*RW-NW){1'b0}}, n} << (2 * FB);
        cnt  <= CW'(RW);
      end
      OP_ROOT_STEP: begin
        srem <= rt_ge ? (rt_rem - rt_trial) : rt_rem;
        root <= {root[RW-2:0], rt_ge};
        rsh  <= {rsh[2*RW-3:0], 2'b00};
        cnt  <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  // Result register; the sequencer only emits into a free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (ctrl.op == OP_EMIT_PRIME || ctrl.op == OP_EMIT_PASS) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT_PRIME) begin
      o_value <= {{(OUT_W-RW){1'b0}}, root};
      o_prime <= 1'b1;
      o_last  <= last_q;
    end else if (ctrl.op == OP_EMIT_PASS) begin
      o_value <= pass_val;
      o_prime <= 1'b0;
      o_last  <= last_q;
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.mapped_value = o_value;
  assign out_ch.prime_flag   = o_prime;
  assign out_ch.last_out     = o_last;

  // Partial remainder stays below the divisor after every step
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_DIV_STEP |=> dr < {1'b0, d})
    else $error("remainder not reduced below divisor");

  // A result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_EMIT_PRIME || ctrl.op == OP_EMIT_PASS) |-> !status.out_busy)
    else $error("result written into a busy slot");

  // A prime result carries its flag and a non-negative root
  a_prime_sign: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_EMIT_PRIME |=> out_ch.prime_flag && !out_ch.mapped_value[OUT_W-1])
    else $error("prime result malformed");

endmodule

@@ design/prime_test_sqrt_map_core.sv @@
// Prime test with square-root map. One word in gives one word out: a prime
// yields its square root truncated to FRACTION_BITS fraction bits, anything
// else its value scaled by 2^FRACTION_BITS, with prime flag and last marker.
// One item is worked at a time. Values of 1 or less and even values other
// than 2 are passed through without trial division. Each odd trial divisor
// goes through the squarer, a bit-serial remainder over VALUE_WIDTH-1 bits
// and a divisor step; a prime, 2 included, then goes through the digit-serial
// root of (VALUE_WIDTH+1)/2+FRACTION_BITS bits. A 31-bit prime takes about
// 23170 divisors. The output register lets the next word in while a result waits.
`timescale 1ns / 1ps

module prime_test_sqrt_map_core
  import ptsm_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  ptsm_in_if.sink    in_ch,
  ptsm_out_if.source out_ch
);

  ctrl_t   ctrl;
  status_t status;

  // Control program
  ptsm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Arithmetic and result register
  ptsm_datapath #(
    .VW (VALUE_WIDTH),
    .FB (FRACTION_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .status (status),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

@@ test/ptsm_checker.sv @@
// Result checker for the prime test and square-root map block.
// Watches both channels, predicts each result word and compares it.
// Depends on ptsm_pkg and the interfaces in ptsm_if.sv.
`timescale 1ns / 1ps

module ptsm_checker
  import ptsm_pkg::*;
#(
  parameter int FRAC = 16
) (
  input  logic clk,
  input  logic rst,
  ptsm_in_if   in_ch,
  ptsm_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic signed [OUT_W-1:0] mapped;
    logic                    prime;
    logic                    last;
  } mapped_word_t;

  mapped_word_t expected_words[$];
  int fails     = 0;
  int waiting   = 0;
  int n_results = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  // Trial division over odd divisors while d*d stays within the value
  function automatic bit is_prime_value(input longint v);
    longint unsigned n, d;
    if (v <= 1) return 1'b0;
    if (v == 2) return 1'b1;
    n = longint'(v);
    if (!n[0]) return 1'b0;
    for (d = 3; d * d <= n; d += 2)
      if (n % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // floor(sqrt(n * 4^FRAC)) found bit by bit from the top
  function automatic longint unsigned root_fixed(input longint unsigned n);
    longint unsigned scaled, r, t;
    scaled = n << (2 * FRAC);
    r = 0;
    for (int b = 16 + FRAC - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= scaled) r = t;
    end
    return r;
  endfunction

  function automatic mapped_word_t map_word(input logic signed [31:0] v, input logic lst);
    mapped_word_t w;
    longint sv, r;
    sv = longint'(v);
    w.prime = is_prime_value(sv);
    if (w.prime) begin
      r = longint'(root_fixed(longint'(sv)));
      if (r > SAT_HI) r = SAT_HI;
    end else begin
      r = sv * (64'sd1 <<< FRAC);
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
    end
    w.mapped = r[OUT_W-1:0];
    w.last   = lst;
    return w;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at result %0d: %s", n_results, msg);
    fails++;
  endtask

  // Predict on input words, compare on output words
  always @(posedge clk) begin
    mapped_word_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        expected_words.push_back(map_word(in_ch.value_in, in_ch.last_in));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = expected_words.pop_front();
          if (out_ch.mapped_value !== want.mapped)
            report($sformatf("mapped_value %0d, expected %0d",
                             out_ch.mapped_value, want.mapped));
          if (out_ch.prime_flag !== want.prime)
            report($sformatf("prime_flag %0b, expected %0b", out_ch.prime_flag, want.prime));
          if (out_ch.last_out !== want.last)
            report($sformatf("last_out %0b, expected %0b", out_ch.last_out, want.last));
        end
        n_results++;
      end
      waiting = expected_words.size();
    end
  end

endmodule

@@ test/tb.sv @@
// Testbench top for prime_test_sqrt_map_core: clock, reset, stimulus,
// random stalls on both channels, watchdog and verdict.
// Depends on ptsm_pkg, ptsm_if.sv, the core and ptsm_checker.
`timescale 1ns / 1ps

module tb
  import ptsm_pkg::*;
;

  localparam int QUIET_LIMIT = 3_000_000;
  localparam int N_RANDOM    = 100;
  localparam int HOLD_AT     = 30;
  localparam int HOLD_CYCLES = 3000;

  // Extremes, tiny values, squares of odd primes and the largest prime
  localparam logic signed [31:0] DIRECTED [20] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd9, 32'sd15,
    32'sd25, 32'sd49, 32'sd97, 32'sd121, 32'sd65521, 32'sh8000_0000,
    32'sh7FFF_FFFE, 32'sh7FFF_FFFD, 32'sh5555_5555, 32'shAAAA_AAAA,
    32'sh7FFF_FFFF
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet = 0;
  int   n_taken = 0;

  ptsm_in_if  in_ch();
  ptsm_out_if out_ch();

  prime_test_sqrt_map_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ptsm_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one word after a random gap, hold it until taken
  task automatic send_word(input logic signed [31:0] v, input logic lst);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.value_in <= v;
    in_ch.last_in  <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stimulus and verdict
  initial begin
    logic signed [31:0] v;
    int sel;
    in_ch.valid    = 1'b0;
    in_ch.value_in = '0;
    in_ch.last_in  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_word(DIRECTED[i], 1'(i));

    // Mostly small values; large ones only where the test ends early
    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= 40 && i < 60);
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        v = $urandom_range(0, 4095);
      end else if (sel < 65) begin
        v = $urandom_range(4096, 1 << 18);
      end else if (sel < 71) begin
        v = -$urandom_range(0, 4096);
      end else if (sel < 77) begin
        v = $urandom;
        v[31] = 1'b1;
      end else if (sel < 89) begin
        v = $urandom;
        v[0] = 1'b0;
      end else begin
        v = 3 * (2 * $urandom_range(0, 357913940) + 1);
      end
      send_word(v, 1'($urandom_range(0, 1)));
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back up the input
  initial begin
    int w;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      w = steady ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      n_taken++;
      if (n_taken == HOLD_AT) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
